### rtl/fair_share_virtual_queue_dropper_top_assert.svh
`ifndef FAIR_SHARE_VIRTUAL_QUEUE_DROPPER_TOP_ASSERT_SVH
`define FAIR_SHARE_VIRTUAL_QUEUE_DROPPER_TOP_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define FSVQ_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define FSVQ_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fsvq_pkg.sv
package fsvq_pkg;

  localparam int BACKLOG_W  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SHARE_FRAC = 16;
  localparam logic [16:0] SHARE_ONE = 17'h10000;

  localparam logic [1:0] CFG_SERVICE_SHARE      = 2'd0;
  localparam logic [1:0] CFG_DROP_THRESHOLD     = 2'd1;
  localparam logic [1:0] CFG_PRIORITY_THRESHOLD = 2'd2;

  localparam logic [2:0] VERDICT_PRIORITY = 3'd0;
  localparam logic [2:0] VERDICT_NORMAL   = 3'd1;
  localparam logic [2:0] VERDICT_DROPPED  = 3'd2;
  localparam logic [2:0] VERDICT_DEPARTED = 3'd3;
  localparam logic [2:0] VERDICT_EMPTY    = 3'd4;

  typedef logic [3:0] cmd_code_t;

  localparam cmd_code_t CMD_NONE       = 4'd0;
  localparam cmd_code_t CMD_CLEAR      = 4'd1;
  localparam cmd_code_t CMD_LOAD       = 4'd2;
  localparam cmd_code_t CMD_REDUCE     = 4'd3;
  localparam cmd_code_t CMD_RD_FLOW    = 4'd4;
  localparam cmd_code_t CMD_CHECK      = 4'd5;
  localparam cmd_code_t CMD_DIV_START  = 4'd6;
  localparam cmd_code_t CMD_ROUND_INIT = 4'd7;
  localparam cmd_code_t CMD_RD_RING    = 4'd8;
  localparam cmd_code_t CMD_RD_VB      = 4'd9;
  localparam cmd_code_t CMD_UPDATE     = 4'd10;
  localparam cmd_code_t CMD_ROUND_END  = 4'd11;
  localparam cmd_code_t CMD_ADMIT      = 4'd12;
  localparam cmd_code_t CMD_POP_SEL    = 4'd13;
  localparam cmd_code_t CMD_POP        = 4'd14;
  localparam cmd_code_t CMD_EMIT       = 4'd15;

  typedef struct packed {
    cmd_code_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic flow_ge;
    logic count_zero;
    logic div_done;
    logic served_zero;
    logic k_last;
    logic round_again;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/fsvq_ram.sv
module fsvq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fsvq_div.sv
module fsvq_div #(
  parameter int DW = 32,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VW-1:0]    rem;
  logic [DW-1:0]    quo;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule

### rtl/fsvq_dp.sv
module fsvq_dp #(
  parameter int FLOWS       = 2048,
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fsvq_pkg::dp_cmd_t    cmd,
  output fsvq_pkg::dp_status_t status,
  input  logic [47:0]          in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [23:0]          out_data,
  output logic [2:0]           out_user
);

  import fsvq_pkg::*;

  localparam int FW    = $clog2(FLOWS);
  localparam int CW    = $clog2(FLOWS + 1);
  localparam int FLW   = (FW > 11) ? FW : 11;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W = BACKLOG_W + FRAC_BITS;

  logic [16:0] service_share;
  logic [15:0] drop_threshold;
  logic [16:0] priority_threshold;

  logic [FLW-1:0]       flow_reg;
  logic [31:0]          elapsed;
  logic                 dropped;
  logic [31:0]          credit;
  logic [31:0]          served;
  logic [CW-1:0]        k;
  logic [CW-1:0]        kept;
  logic [CW-1:0]        count;
  logic [FW-1:0]        cur_f;
  logic [FW-1:0]        clr;
  logic [QW-1:0]        p_head, n_head;
  logic [QCW-1:0]       p_fill, n_fill;
  logic                 pop_prio;
  logic                 pop_hit;
  logic [2:0]           res_verdict;
  logic [FW-1:0]        res_departed;

  logic [FW-1:0]        flow_idx;
  logic [16:0]          share_eff;
  logic [48:0]          product;
  logic [31:0]          div_quot;
  logic                 div_done;

  logic                 vb_we;
  logic [FW-1:0]        vb_waddr, vb_raddr;
  logic [31:0]          vb_wdata, vb_rdata;
  logic                 ring_we;
  logic [FW-1:0]        ring_waddr, ring_wdata, ring_rdata;
  logic                 pf_we, nf_we;
  logic [FW-1:0]        pf_rdata, nf_rdata;
  logic [QW-1:0]        tail;

  logic [32:0]          v_sum;
  logic [31:0]          v_sat;
  logic                 prio;
  logic                 full;
  logic                 admit;
  logic                 join_ring;
  logic                 keep;
  logic [QW:0]          tail_sum;

  assign flow_idx  = flow_reg[FW-1:0];
  assign share_eff = (service_share > SHARE_ONE) ? SHARE_ONE : service_share;
  assign product   = elapsed * share_eff;

  // Admission arithmetic on the virtual queue after the drain.
  assign v_sum = {1'b0, vb_rdata} + 33'(1 << FRAC_BITS);
  assign v_sat = v_sum[32] ? 32'hFFFF_FFFF : v_sum[31:0];
  assign prio  = !priority_threshold[16]
                 && (LIM_W'(v_sat) <= (LIM_W'(priority_threshold[15:0]) << FRAC_BITS));
  assign full  = prio ? (p_fill == QCW'(QUEUE_DEPTH)) : (n_fill == QCW'(QUEUE_DEPTH));
  assign admit = !dropped && !full;
  assign join_ring = admit && (vb_rdata == '0) && (count < CW'(FLOWS));
  assign keep  = vb_rdata > served;

  always_comb begin
    if (prio) begin
      tail_sum = (QW + 1)'(p_head) + (QW + 1)'(p_fill);
    end else begin
      tail_sum = (QW + 1)'(n_head) + (QW + 1)'(n_fill);
    end
    if (tail_sum >= (QW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QW + 1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QW-1:0];
  end

  always_comb begin
    vb_we    = 1'b0;
    vb_waddr = flow_idx;
    vb_wdata = v_sat;
    ring_we    = 1'b0;
    ring_waddr = count[FW-1:0];
    ring_wdata = flow_idx;
    pf_we = 1'b0;
    nf_we = 1'b0;
    unique case (cmd.code)
      CMD_CLEAR: begin
        vb_we    = 1'b1;
        vb_waddr = clr;
        vb_wdata = '0;
      end
      CMD_UPDATE: begin
        vb_we      = 1'b1;
        vb_waddr   = cur_f;
        vb_wdata   = keep ? (vb_rdata - served) : '0;
        ring_we    = keep;
        ring_waddr = kept[FW-1:0];
        ring_wdata = cur_f;
      end
      CMD_ADMIT: begin
        vb_we   = admit;
        ring_we = join_ring;
        pf_we   = admit && prio;
        nf_we   = admit && !prio;
      end
      default: begin
      end
    endcase
  end

  assign vb_raddr = (cmd.code == CMD_RD_VB) ? ring_rdata : flow_idx;

  fsvq_ram #(.WIDTH(32), .DEPTH(FLOWS)) u_vb_ram (
    .clk(clk), .we(vb_we), .waddr(vb_waddr), .wdata(vb_wdata),
    .raddr(vb_raddr), .rdata(vb_rdata)
  );

  fsvq_ram #(.WIDTH(FW), .DEPTH(FLOWS)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(k[FW-1:0]), .rdata(ring_rdata)
  );

  fsvq_ram #(.WIDTH(FW), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
    .clk(clk), .we(pf_we), .waddr(tail), .wdata(flow_idx),
    .raddr(p_head), .rdata(pf_rdata)
  );

  fsvq_ram #(.WIDTH(FW), .DEPTH(QUEUE_DEPTH)) u_norm_ram (
    .clk(clk), .we(nf_we), .waddr(tail), .wdata(flow_idx),
    .raddr(n_head), .rdata(nf_rdata)
  );

  fsvq_div #(.DW(32), .VW(CW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.code == CMD_DIV_START),
    .dividend(credit), .divisor(count), .quotient(div_quot), .done(div_done)
  );

  // Control state: configuration, ring size, FIFO pointers, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      service_share      <= SHARE_ONE;
      drop_threshold     <= 16'd10;
      priority_threshold <= 17'h1FFFF;
      count     <= '0;
      clr       <= '0;
      p_head    <= '0;
      p_fill    <= '0;
      n_head    <= '0;
      n_fill    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SERVICE_SHARE:      service_share      <= cfg_data;
          CFG_DROP_THRESHOLD:     drop_threshold     <= cfg_data[15:0];
          CFG_PRIORITY_THRESHOLD: priority_threshold <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.code == CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.code)
        CMD_CLEAR: clr <= clr + 1'b1;
        CMD_ROUND_END: count <= kept;
        CMD_ADMIT: begin
          if (join_ring) begin
            count <= count + 1'b1;
          end
          if (admit && prio) begin
            p_fill <= p_fill + 1'b1;
          end
          if (admit && !prio) begin
            n_fill <= n_fill + 1'b1;
          end
        end
        CMD_POP: begin
          if (pop_hit && pop_prio) begin
            p_head <= (p_head == QW'(QUEUE_DEPTH - 1)) ? '0 : p_head + 1'b1;
            p_fill <= p_fill - 1'b1;
          end
          if (pop_hit && !pop_prio) begin
            n_head <= (n_head == QW'(QUEUE_DEPTH - 1)) ? '0 : n_head + 1'b1;
            n_fill <= n_fill - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    unique case (cmd.code)
      CMD_LOAD: begin
        flow_reg <= FLW'(in_data[10:0]);
        elapsed  <= in_data[42:11];
      end
      CMD_REDUCE: flow_reg <= flow_reg - FLW'(FLOWS);
      CMD_CHECK: begin
        dropped <= LIM_W'(vb_rdata) > (LIM_W'(drop_threshold) << FRAC_BITS);
        credit  <= product[SHARE_FRAC+31:SHARE_FRAC];
      end
      CMD_ROUND_INIT: begin
        served <= div_quot;
        credit <= '0;
        k      <= '0;
        kept   <= '0;
      end
      CMD_RD_VB: cur_f <= ring_rdata;
      CMD_UPDATE: begin
        k <= k + 1'b1;
        if (keep) begin
          kept <= kept + 1'b1;
        end else begin
          credit <= credit + (served - vb_rdata);
        end
      end
      CMD_ADMIT: begin
        res_departed <= '0;
        if (!admit) begin
          res_verdict <= VERDICT_DROPPED;
        end else if (prio) begin
          res_verdict <= VERDICT_PRIORITY;
        end else begin
          res_verdict <= VERDICT_NORMAL;
        end
      end
      CMD_POP_SEL: begin
        pop_prio <= p_fill != '0;
        pop_hit  <= (p_fill != '0) || (n_fill != '0);
      end
      CMD_POP: begin
        if (pop_hit) begin
          res_verdict  <= VERDICT_DEPARTED;
          res_departed <= pop_prio ? pf_rdata : nf_rdata;
        end else begin
          res_verdict  <= VERDICT_EMPTY;
          res_departed <= '0;
        end
      end
      CMD_EMIT: begin
        out_user <= res_verdict;
        out_data <= {1'b0, 12'(count), 11'(res_departed)};
      end
      default: begin
      end
    endcase
  end

  assign status.clr_last    = clr == FW'(FLOWS - 1);
  assign status.flow_ge     = {1'b0, flow_reg} >= (FLW + 1)'(FLOWS);
  assign status.count_zero  = count == '0;
  assign status.div_done    = div_done;
  assign status.served_zero = div_quot == '0;
  assign status.k_last      = k == (count - 1'b1);
  assign status.round_again = (kept < count) && (kept != '0);
  assign status.out_free    = !out_valid || out_ready;

endmodule

### rtl/fsvq_ctrl.sv
module fsvq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  input  fsvq_pkg::dp_status_t status,
  output fsvq_pkg::dp_cmd_t    cmd
);

  import fsvq_pkg::*;

  localparam logic [3:0] S_CLEAR      = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_REDUCE     = 4'd2;
  localparam logic [3:0] S_CHECK      = 4'd3;
  localparam logic [3:0] S_DIV_START  = 4'd4;
  localparam logic [3:0] S_DIV        = 4'd5;
  localparam logic [3:0] S_ROUND_INIT = 4'd6;
  localparam logic [3:0] S_RD_RING    = 4'd7;
  localparam logic [3:0] S_RD_VB      = 4'd8;
  localparam logic [3:0] S_UPDATE     = 4'd9;
  localparam logic [3:0] S_ROUND_END  = 4'd10;
  localparam logic [3:0] S_RD_FLOW    = 4'd11;
  localparam logic [3:0] S_ADMIT      = 4'd12;
  localparam logic [3:0] S_POP_SEL    = 4'd13;
  localparam logic [3:0] S_POP        = 4'd14;
  localparam logic [3:0] S_FINISH     = 4'd15;

  logic [3:0] state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.code   = CMD_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.code = CMD_CLEAR;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.code   = CMD_LOAD;
          state_next = in_op ? S_POP_SEL : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.flow_ge) begin
          cmd.code = CMD_REDUCE;
        end else begin
          cmd.code   = CMD_RD_FLOW;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.code   = CMD_CHECK;
        state_next = status.count_zero ? S_RD_FLOW : S_DIV_START;
      end
      S_DIV_START: begin
        cmd.code   = CMD_DIV_START;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_ROUND_INIT;
        end
      end
      S_ROUND_INIT: begin
        cmd.code = CMD_ROUND_INIT;
        // Nothing is served in this round, so every flow stays and the drain ends.
        state_next = status.served_zero ? S_RD_FLOW : S_RD_RING;
      end
      S_RD_RING: begin
        cmd.code   = CMD_RD_RING;
        state_next = S_RD_VB;
      end
      S_RD_VB: begin
        cmd.code   = CMD_RD_VB;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.code   = CMD_UPDATE;
        state_next = status.k_last ? S_ROUND_END : S_RD_RING;
      end
      S_ROUND_END: begin
        cmd.code   = CMD_ROUND_END;
        state_next = status.round_again ? S_DIV_START : S_RD_FLOW;
      end
      S_RD_FLOW: begin
        cmd.code   = CMD_RD_FLOW;
        state_next = S_ADMIT;
      end
      S_ADMIT: begin
        cmd.code   = CMD_ADMIT;
        state_next = S_FINISH;
      end
      S_POP_SEL: begin
        cmd.code   = CMD_POP_SEL;
        state_next = S_POP;
      end
      S_POP: begin
        cmd.code   = CMD_POP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.code   = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/fair_share_virtual_queue_dropper_top.sv
// Channel | Dir | Signals                         | Fields
// s_axis  | in  | tvalid tready tdata[47:0] tuser | tuser operation; tdata flow_id, elapsed_time
// m_axis  | out | tvalid tready tdata[23:0] tuser | tuser verdict; tdata departed_flow, backlogged
// cfg     | in  | cfg_we cfg_index cfg_data[16:0] | 0 share, 1 drop thresh, 2 priority thresh
//
// One word is worked on at a time. A departure passes through pop selection and the pop, an
// arrival through flow reduction, the check and admission, plus per drain round the serial
// divider and round bookkeeping and per backlogged flow a walk over the ring memory.
// After reset a clearing pass writes zero to every virtual queue, with s_axis_tready
// low; configuration writes are taken throughout. A finished result waits in the output
// register; a stalled m_axis holds the next result in the datapath while the controller waits.
`include "fair_share_virtual_queue_dropper_top_assert.svh"

module fair_share_virtual_queue_dropper_top #(
  parameter int FLOWS       = 2048,
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // flow_id[10:0], elapsed_time[42:11], zero[47:43]
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // departed_flow[10:0], backlogged_count[22:11], zero[23]
  output logic [2:0]  m_axis_tuser,  // verdict
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  import fsvq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fsvq_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_op(s_axis_tuser), .in_ready(s_axis_tready),
    .status(status), .cmd(cmd)
  );

  fsvq_dp #(.FLOWS(FLOWS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_data(s_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_ready(m_axis_tready), .out_valid(m_axis_tvalid),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser)
  );

  `FSVQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an item is in work")
  `FSVQ_ASSERT_NOW(a_verdict_code, clk, rst, m_axis_tvalid, m_axis_tuser <= VERDICT_EMPTY, "verdict out of range")
  `FSVQ_ASSERT_NOW(a_count_bound, clk, rst, m_axis_tvalid, 32'(m_axis_tdata[22:11]) <= 32'(FLOWS), "backlogged count above flow count")

endmodule
